// ===== rtl/core/srlb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srlb_pkg: shared types and constants for the shift register LED bank
// Command codes, controller state, and the control/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package srlb_pkg;

    localparam int CHIP_COUNT_W = 4;
    localparam int LED_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int POS_W        = 3;
    localparam int BIT_W        = 3;

    localparam logic [CHIP_COUNT_W-1:0] CHIP_COUNT_RESET = 4'd8;
    localparam logic [BYTE_W-1:0]       BYTE_ALL_ON      = 8'hFF;
    localparam logic [BYTE_W-1:0]       BYTE_ALL_OFF     = 8'h00;

    typedef enum logic [2:0] {
        MODE_SET        = 3'd0,
        MODE_CLEAR      = 3'd1,
        MODE_ALL_ON     = 3'd2,
        MODE_ALL_OFF    = 3'd3,
        MODE_WALK_START = 3'd4,
        MODE_WALK_STEP  = 3'd5,
        MODE_WALK_STOP  = 3'd6,
        MODE_QUERY      = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EMIT  = 2'd1,
        ST_QUERY = 2'd2
    } state_t;

    typedef struct packed {
        logic accept;
        logic emit_load;
        logic query_load;
    } cmd_t;

    typedef struct packed {
        logic walk_active;
        logic slot_free;
        logic cnt_last;
    } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/shift_register_led_bank.sv =====
`default_nettype none
// Start: after the command transfer the controller enters its emit or query state;
//   the first byte of a frame or a query answer loads once the output register is free.
// Output: a frame command emits one byte per chip in use (chip_count clamped to
//   1..MAX_CHIPS), a query one answer, and walk start, walk stop or an idle walk
//   step none; one stored byte is read per cycle while the output does not stall.
// Reset: LED bytes clear, walk stops at LED 0, chip_count returns to 8.
// ----------------------------------------------------------------------------
// shift_register_led_bank: LED bank for a chain of 8-bit shift registers
// Keeps one LED byte per chip and streams the chain frame after each
// change, chip 0 first, with the latch marked on the final byte; a query returns one LED's state.
// ----------------------------------------------------------------------------
module shift_register_led_bank #(
    parameter int MAX_CHIPS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [srlb_pkg::CHIP_COUNT_W-1:0] cfg_wr_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [2:0]                        mode,
    input  wire logic [srlb_pkg::LED_W-1:0]        led_index,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [srlb_pkg::BYTE_W-1:0]            chip_byte,
    output logic [srlb_pkg::POS_W-1:0]             chip_position,
    output logic                                   led_on,
    output logic                                   last
);

    srlb_pkg::cmd_t    cmd;
    srlb_pkg::status_t status;

    srlb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    srlb_datapath #(
        .MAX_CHIPS (MAX_CHIPS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .mode          (mode),
        .led_index     (led_index),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .out_stall     (out_stall),
        .status        (status),
        .out_valid     (out_valid),
        .chip_byte     (chip_byte),
        .chip_position (chip_position),
        .led_on        (led_on),
        .last          (last)
    );

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_load || cmd.query_load) |-> status.slot_free)
        else $error("output register loaded while a result still waits");

    a_accept_excludes_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> (!cmd.emit_load && !cmd.query_load))
        else $error("command transfer overlaps an output load");

    a_query_answer_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && led_on) |-> (last && (chip_byte == '0)))
        else $error("lit LED flag outside a query answer");

    a_no_load_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> (!cmd.emit_load && !cmd.query_load))
        else $error("output load while taking commands");

endmodule
`default_nettype wire

// ===== rtl/core/srlb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srlb_ctrl: command sequencer
// Takes one command at a time, then walks the frame bytes or the single
// query answer into the output register as slots free up.
// ----------------------------------------------------------------------------
module srlb_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [2:0]       mode,
    input  wire srlb_pkg::status_t status,
    output srlb_pkg::cmd_t        cmd,
    output logic                  in_stall
);

    srlb_pkg::state_t state_reg;
    srlb_pkg::state_t state_next;
    srlb_pkg::mode_t  mode_e;

    assign mode_e = srlb_pkg::mode_t'(mode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srlb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srlb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (mode_e) inside
                        srlb_pkg::MODE_SET, srlb_pkg::MODE_CLEAR,
                        srlb_pkg::MODE_ALL_ON, srlb_pkg::MODE_ALL_OFF:
                            state_next = srlb_pkg::ST_EMIT;
                        srlb_pkg::MODE_WALK_STEP:
                            state_next = status.walk_active ? srlb_pkg::ST_EMIT
                                                            : srlb_pkg::ST_IDLE;
                        srlb_pkg::MODE_QUERY:
                            state_next = srlb_pkg::ST_QUERY;
                        default:
                            state_next = srlb_pkg::ST_IDLE;
                    endcase
                end
            end
            srlb_pkg::ST_EMIT:
            begin
                if (status.slot_free && status.cnt_last)
                begin
                    state_next = srlb_pkg::ST_IDLE;
                end
            end
            srlb_pkg::ST_QUERY:
            begin
                if (status.slot_free)
                begin
                    state_next = srlb_pkg::ST_IDLE;
                end
            end
            default:
                state_next = srlb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.accept     = 1'b0;
        cmd.emit_load  = 1'b0;
        cmd.query_load = 1'b0;
        in_stall       = 1'b1;
        unique case (state_reg)
            srlb_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            srlb_pkg::ST_EMIT:
                cmd.emit_load = status.slot_free;
            srlb_pkg::ST_QUERY:
                cmd.query_load = status.slot_free;
            default:
                in_stall = 1'b1;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/srlb_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srlb_datapath: LED byte bank, walk state and output register
// Applies each command to the bank on the transfer edge, then reads one
// stored byte per load into the output register.
// ----------------------------------------------------------------------------
module srlb_datapath #(
    parameter int MAX_CHIPS = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire srlb_pkg::cmd_t                       cmd,
    input  wire logic [2:0]                           mode,
    input  wire logic [srlb_pkg::LED_W-1:0]           led_index,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [srlb_pkg::CHIP_COUNT_W-1:0]    cfg_wr_data,
    input  wire logic                                 out_stall,
    output srlb_pkg::status_t                         status,
    output logic                                      out_valid,
    output logic [srlb_pkg::BYTE_W-1:0]               chip_byte,
    output logic [srlb_pkg::POS_W-1:0]                chip_position,
    output logic                                      led_on,
    output logic                                      last
);

    localparam int CIDX_W = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
    localparam int CW     = srlb_pkg::CHIP_COUNT_W;
    localparam int BW     = srlb_pkg::BYTE_W;
    localparam int LW     = srlb_pkg::LED_W;
    localparam int TW     = srlb_pkg::BIT_W;

    logic [CW-1:0]     chip_count_reg;
    logic [BW-1:0]     bank_reg  [MAX_CHIPS];
    logic [BW-1:0]     bank_next [MAX_CHIPS];
    logic [LW-1:0]     walk_pos_reg;
    logic [LW-1:0]     walk_pos_next;
    logic              walk_active_reg;
    logic              walk_active_next;
    logic [CIDX_W-1:0] cnt_reg;
    logic [CIDX_W-1:0] q_chip_reg;
    logic [TW-1:0]     q_bit_reg;
    logic              q_hit_reg;
    logic              out_valid_reg;
    logic [BW-1:0]     out_byte_reg;
    logic [srlb_pkg::POS_W-1:0] out_pos_reg;
    logic              out_led_reg;
    logic              out_last_reg;

    srlb_pkg::mode_t   mode_e;
    logic [CW-1:0]     chips_n;
    logic [CIDX_W-1:0] cnt_max;
    logic              led_hit;
    logic [CW-1:0]     led_chip;
    logic              walk_hit;
    logic [CW-1:0]     walk_chip;
    logic [LW:0]       walk_inc;
    logic [CIDX_W-1:0] rd_addr;
    logic [BW-1:0]     rd_byte;
    logic              slot_free;

    assign mode_e = srlb_pkg::mode_t'(mode);

    // Clamp the chip count into 1..MAX_CHIPS
    always_comb
    begin
        if (chip_count_reg == '0)
        begin
            chips_n = CW'(1);
        end
        else if (chip_count_reg > CW'(MAX_CHIPS))
        begin
            chips_n = CW'(MAX_CHIPS);
        end
        else
        begin
            chips_n = chip_count_reg;
        end
    end

    assign cnt_max   = CIDX_W'(chips_n - CW'(1));
    assign led_hit   = ({1'b0, led_index[LW-1:TW]} < chips_n);
    assign led_chip  = chips_n - CW'(1) - {1'b0, led_index[LW-1:TW]};
    assign walk_hit  = ({1'b0, walk_pos_reg[LW-1:TW]} < chips_n);
    assign walk_chip = chips_n - CW'(1) - {1'b0, walk_pos_reg[LW-1:TW]};
    assign walk_inc  = {1'b0, walk_pos_reg} + (LW+1)'(1);

    // Bank update, applied on the command transfer edge
    always_comb
    begin
        for (int i = 0; i < MAX_CHIPS; i++)
        begin
            bank_next[i] = bank_reg[i];
            if (cmd.accept)
            begin
                case (mode_e)
                    srlb_pkg::MODE_SET:
                        if (led_hit && (CW'(i) == led_chip))
                        begin
                            bank_next[i] = bank_reg[i] | (BW'(1) << led_index[TW-1:0]);
                        end
                    srlb_pkg::MODE_CLEAR:
                        if (led_hit && (CW'(i) == led_chip))
                        begin
                            bank_next[i] = bank_reg[i] & ~(BW'(1) << led_index[TW-1:0]);
                        end
                    srlb_pkg::MODE_ALL_ON:
                        if (CW'(i) < chips_n)
                        begin
                            bank_next[i] = srlb_pkg::BYTE_ALL_ON;
                        end
                    srlb_pkg::MODE_ALL_OFF:
                        if (CW'(i) < chips_n)
                        begin
                            bank_next[i] = srlb_pkg::BYTE_ALL_OFF;
                        end
                    srlb_pkg::MODE_WALK_STEP:
                        if (walk_active_reg && (CW'(i) < chips_n))
                        begin
                            if (walk_hit && (CW'(i) == walk_chip))
                            begin
                                bank_next[i] = BW'(1) << walk_pos_reg[TW-1:0];
                            end
                            else
                            begin
                                bank_next[i] = srlb_pkg::BYTE_ALL_OFF;
                            end
                        end
                    default:
                        bank_next[i] = bank_reg[i];
                endcase
            end
        end
    end

    // Walk state
    always_comb
    begin
        walk_pos_next    = walk_pos_reg;
        walk_active_next = walk_active_reg;
        if (cmd.accept)
        begin
            case (mode_e)
                srlb_pkg::MODE_WALK_START:
                begin
                    walk_pos_next    = '0;
                    walk_active_next = 1'b1;
                end
                srlb_pkg::MODE_WALK_STEP:
                    if (walk_active_reg)
                    begin
                        // stop and rewind once the walk runs off the last LED
                        if (walk_inc >= {chips_n, 3'b000})
                        begin
                            walk_pos_next    = '0;
                            walk_active_next = 1'b0;
                        end
                        else
                        begin
                            walk_pos_next = walk_inc[LW-1:0];
                        end
                    end
                srlb_pkg::MODE_WALK_STOP:
                    walk_active_next = 1'b0;
                default:
                    walk_active_next = walk_active_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_count_reg  <= srlb_pkg::CHIP_COUNT_RESET;
            walk_pos_reg    <= '0;
            walk_active_reg <= 1'b0;
            for (int i = 0; i < MAX_CHIPS; i++)
            begin
                bank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                chip_count_reg <= cfg_wr_data;
            end
            walk_pos_reg    <= walk_pos_next;
            walk_active_reg <= walk_active_next;
            for (int i = 0; i < MAX_CHIPS; i++)
            begin
                bank_reg[i] <= bank_next[i];
            end
        end
    end

    // Frame counter and latched query target
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            q_chip_reg <= '0;
            q_bit_reg  <= '0;
            q_hit_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                cnt_reg    <= '0;
                q_hit_reg  <= led_hit;
                q_bit_reg  <= led_index[TW-1:0];
                q_chip_reg <= led_hit ? CIDX_W'(led_chip) : '0;
            end
            else if (cmd.emit_load)
            begin
                cnt_reg <= (cnt_reg == cnt_max) ? '0 : cnt_reg + CIDX_W'(1);
            end
        end
    end

    assign rd_addr   = cmd.query_load ? q_chip_reg : cnt_reg;
    assign rd_byte   = bank_reg[rd_addr];
    assign slot_free = !out_valid_reg || !out_stall;

    // Output register: hold while stalled, load when the slot frees
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load || cmd.query_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_byte_reg <= rd_byte;
            out_pos_reg  <= srlb_pkg::POS_W'(cnt_reg);
            out_led_reg  <= 1'b0;
            out_last_reg <= (cnt_reg == cnt_max);
        end
        else if (cmd.query_load)
        begin
            out_byte_reg <= '0;
            out_pos_reg  <= srlb_pkg::POS_W'(q_chip_reg);
            out_led_reg  <= q_hit_reg & rd_byte[q_bit_reg];
            out_last_reg <= 1'b1;
        end
    end

    assign status.walk_active = walk_active_reg;
    assign status.slot_free   = slot_free;
    assign status.cnt_last    = (cnt_reg == cnt_max);

    assign out_valid     = out_valid_reg;
    assign chip_byte     = out_byte_reg;
    assign chip_position = out_pos_reg;
    assign led_on        = out_led_reg;
    assign last          = out_last_reg;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the shift register LED bank
// Drives LED commands through the valid/stall port and predicts every chain
// byte and query answer. Covers a directed table, several chip counts and
// random command sequences under sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srlb_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_CMDS    = 35;
    localparam int N_DIR         = 29;

    // one emitted chain byte or query answer
    typedef struct packed {
        logic [BYTE_W-1:0] chip_val;
        logic [POS_W-1:0]  pos;
        logic              lit;
        logic              fin;
    } chain_beat_t;

    // directed row: either a chip_count write or one command
    typedef struct packed {
        logic                    is_cfg;
        logic [CHIP_COUNT_W-1:0] count;
        mode_t                   cmd;
        logic [LED_W-1:0]        idx;
        logic                    typed;
        logic [POS_W-1:0]        pos;
        logic                    lit;
    } dir_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [CHIP_COUNT_W-1:0] cfg_wr_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [2:0]              mode;
    logic [LED_W-1:0]        led_index;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [BYTE_W-1:0]       chip_byte;
    logic [POS_W-1:0]        chip_position;
    logic                    led_on;
    logic                    last;

    // predictor state
    logic [BYTE_W-1:0]       bank [8];
    logic [LED_W-1:0]        walk_pos;
    logic                    walk_on;
    logic [CHIP_COUNT_W-1:0] chips_cfg;
    chain_beat_t             expected_beats [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatches    = 0;
    int cmds_sent     = 0;
    int frame_cmds    = 0;
    int beats_seen    = 0;
    int cfg_writes    = 0;

    dir_row_t dir_table [N_DIR];

    shift_register_led_bank uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .led_index     (led_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .chip_byte     (chip_byte),
        .chip_position (chip_position),
        .led_on        (led_on),
        .last          (last)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("timeout: %0d expected bytes still pending", expected_beats.size());
        $display("RESULT: ERROR");
        $finish;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int unsigned chips_used();
        if (chips_cfg == 0)
            return 1;
        if (chips_cfg > 8)
            return 8;
        return chips_cfg;
    endfunction

    task automatic light_led(input int unsigned led, input logic on, input int unsigned n);
        int unsigned chip;
        if (led < n * 8)
        begin
            chip = n - 1 - led / 8;
            bank[chip][led % 8] = on;
        end
    endtask

    task automatic push_frame(input int unsigned n);
        chain_beat_t b;
        for (int unsigned k = 0; k < n; k++)
        begin
            b.chip_val = bank[k];
            b.pos      = k[POS_W-1:0];
            b.lit      = 1'b0;
            b.fin      = (k + 1 == n);
            expected_beats.push_back(b);
        end
        frame_cmds++;
    endtask

    task automatic apply_command(input mode_t cmd, input logic [LED_W-1:0] idx);
        int unsigned n;
        int unsigned chip;
        chain_beat_t b;
        n = chips_used();
        case (cmd)
            MODE_SET:
            begin
                light_led(idx, 1'b1, n);
                push_frame(n);
            end
            MODE_CLEAR:
            begin
                light_led(idx, 1'b0, n);
                push_frame(n);
            end
            MODE_ALL_ON, MODE_ALL_OFF:
            begin
                for (int unsigned k = 0; k < n; k++)
                    bank[k] = (cmd == MODE_ALL_ON) ? BYTE_ALL_ON : BYTE_ALL_OFF;
                push_frame(n);
            end
            MODE_WALK_START:
            begin
                walk_pos = '0;
                walk_on  = 1'b1;
            end
            MODE_WALK_STEP:
            begin
                if (walk_on)
                begin
                    for (int unsigned k = 0; k < n; k++)
                        bank[k] = BYTE_ALL_OFF;
                    light_led(walk_pos, 1'b1, n);
                    push_frame(n);
                    // stop at the end of the chain and rewind
                    if (int'(walk_pos) + 1 >= n * 8)
                    begin
                        walk_on  = 1'b0;
                        walk_pos = '0;
                    end
                    else
                        walk_pos = walk_pos + 1'b1;
                end
            end
            MODE_WALK_STOP:
                walk_on = 1'b0;
            default:
            begin
                chip = 0;
                b.lit = 1'b0;
                if (idx < n * 8)
                begin
                    chip  = n - 1 - idx / 8;
                    b.lit = bank[chip][idx % 8];
                end
                b.chip_val = '0;
                b.pos      = chip[POS_W-1:0];
                b.fin      = 1'b1;
                expected_beats.push_back(b);
                frame_cmds++;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input chain_beat_t exp_b,
                                 input chain_beat_t got_b);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t %s: expected byte=%02h pos=%0d on=%b last=%b",
                     $time, what, exp_b.chip_val, exp_b.pos, exp_b.lit, exp_b.fin);
            $display("    got byte=%02h pos=%0d on=%b last=%b",
                     got_b.chip_val, got_b.pos, got_b.lit, got_b.fin);
        end
    endtask

    always @(posedge clk)
    begin
        chain_beat_t got_b;
        chain_beat_t exp_b;
        if (rst_n && out_valid && !out_stall)
        begin
            got_b = {chip_byte, chip_position, led_on, last};
            beats_seen++;
            if (expected_beats.size() == 0)
            begin
                exp_b = '0;
                note_mismatch("transfer with nothing expected", exp_b, got_b);
            end
            else
            begin
                exp_b = expected_beats.pop_front();
                if (got_b !== exp_b)
                    note_mismatch("chain byte mismatch", exp_b, got_b);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    // Hold the command until the transfer, then predict its results.
    task automatic issue(input mode_t cmd, input logic [LED_W-1:0] idx);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= cmd;
        led_index <= idx;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        cmds_sent++;
        apply_command(cmd, idx);
    endtask

    // Drain every pending result, then give commands with no output time to retire.
    task automatic settle_bank();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_chip_count(input logic [CHIP_COUNT_W-1:0] value);
        settle_bank();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        chips_cfg = value;
        cfg_writes++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [LED_W-1:0] pick_led();
        if ($urandom_range(9) == 0)
            return LED_W'($urandom_range(63));
        return LED_W'($urandom_range(chips_used() * 8 - 1));
    endfunction

    task automatic random_sequence();
        int unsigned r;
        int unsigned steps;
        logic [LED_W-1:0] led;
        r = $urandom_range(99);
        if (r < 25)
        begin
            issue(MODE_WALK_START, LED_W'($urandom_range(63)));
            steps = $urandom_range(1, 12);
            for (int unsigned s = 0; s < steps; s++)
            begin
                // occasionally break the walk partway through
                if ($urandom_range(9) == 0)
                    issue(MODE_WALK_STOP, LED_W'($urandom_range(63)));
                issue(MODE_WALK_STEP, LED_W'($urandom_range(63)));
            end
        end
        else if (r < 55)
        begin
            led = pick_led();
            issue(MODE_SET, led);
            issue(MODE_QUERY, led);
            if ($urandom_range(1))
            begin
                issue(MODE_CLEAR, led);
                issue(MODE_QUERY, $urandom_range(1) ? led : pick_led());
            end
        end
        else if (r < 65)
        begin
            issue(mode_t'($urandom_range(1) ? MODE_ALL_ON : MODE_ALL_OFF),
                  LED_W'($urandom_range(63)));
            issue(MODE_QUERY, pick_led());
        end
        else
            issue(mode_t'($urandom_range(7)), LED_W'($urandom_range(63)));
    endtask

    task automatic random_phase(input logic [CHIP_COUNT_W-1:0] count, input int idle,
                                input int stall);
        int goal;
        write_chip_count(count);
        send_idle_pct = idle;
        stall_pct     = stall;
        // a walk left open by the last phase may now sit past the chain end
        issue(MODE_WALK_STEP, LED_W'($urandom_range(63)));
        goal = frame_cmds + PHASE_CMDS;
        while (frame_cmds < goal)
            random_sequence();
        // leave a walk running into the next chip count
        issue(MODE_WALK_START, LED_W'($urandom_range(63)));
        repeat ($urandom_range(8, 20))
            issue(MODE_WALK_STEP, LED_W'($urandom_range(63)));
    endtask

    initial
    begin
        chain_beat_t tail;

        dir_table = '{
            '{1'b0, 4'd0, MODE_QUERY,      6'd0,  1'b1, 3'd7, 1'b0},
            '{1'b0, 4'd0, MODE_SET,        6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_SET,        6'd63, 1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_QUERY,      6'd63, 1'b1, 3'd0, 1'b1},
            '{1'b0, 4'd0, MODE_CLEAR,      6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_QUERY,      6'd0,  1'b1, 3'd7, 1'b0},
            '{1'b0, 4'd0, MODE_ALL_ON,     6'd42, 1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_QUERY,      6'd42, 1'b1, 3'd2, 1'b1},
            '{1'b0, 4'd0, MODE_ALL_OFF,    6'd21, 1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_STEP,  6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_START, 6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_STEP,  6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_START, 6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_STEP,  6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_STOP,  6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_STEP,  6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b1, 4'd0, MODE_SET,        6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_SET,        6'd8,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_QUERY,      6'd8,  1'b1, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_START, 6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_STEP,  6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_STEP,  6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_STEP,  6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_STEP,  6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_STEP,  6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_STEP,  6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_STEP,  6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_STEP,  6'd0,  1'b0, 3'd0, 1'b0},
            '{1'b0, 4'd0, MODE_WALK_STEP,  6'd0,  1'b0, 3'd0, 1'b0}
        };

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        mode        = MODE_SET;
        led_index   = '0;
        for (int k = 0; k < 8; k++)
            bank[k] = '0;
        walk_pos  = '0;
        walk_on   = 1'b0;
        chips_cfg = CHIP_COUNT_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table, reset chip count first
        foreach (dir_table[i])
        begin
            if (dir_table[i].is_cfg)
                write_chip_count(dir_table[i].count);
            else
            begin
                issue(dir_table[i].cmd, dir_table[i].idx);
                if (dir_table[i].typed)
                begin
                    tail     = expected_beats[expected_beats.size() - 1];
                    tail.pos = dir_table[i].pos;
                    tail.lit = dir_table[i].lit;
                    expected_beats[expected_beats.size() - 1] = tail;
                end
            end
        end

        random_phase(4'd15, 0, 0);
        random_phase(4'd1, 78, 0);
        random_phase(4'd3, 0, 78);
        random_phase(CHIP_COUNT_W'($urandom_range(15)), 15, 15);

        settle_bank();
        if (expected_beats.size() != 0)
        begin
            mismatches += expected_beats.size();
            $display("%0d expected bytes never arrived", expected_beats.size());
        end

        $display("Sent %0d commands (%0d with output), checked %0d chain bytes and answers",
                 cmds_sent, frame_cmds, beats_seen);
        $display("over %0d chip-count writes and four idle/stall mixes; %0d mismatches",
                 cfg_writes, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
